### hw/rtl/rars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_pkg
// shared types and sizing for the range add / range sum segment tree
// ----------------------------------------------------------------------------
package rars_pkg;

    localparam int LEAVES    = 1024;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 64;

    // tree geometry
    localparam int TREE_LVLS = $clog2(LEAVES);
    localparam int SPAN      = 1 << TREE_LVLS;
    localparam int NW        = TREE_LVLS + 1;
    localparam int LW        = $clog2(TREE_LVLS + 1);
    localparam int CW        = (TREE_LVLS > IDX_W) ? TREE_LVLS : IDX_W;

    localparam logic [CW-1:0] LAST_IDX = CW'(LEAVES - 1);

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_REBUILD = 2'd1,
        KIND_ADD     = 2'd2,
        KIND_SUM     = 2'd3
    } kind_t;

endpackage

### hw/rtl/rars_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_req_if
// request channel: operation kind, index range and value
// ----------------------------------------------------------------------------
interface rars_req_if;
    logic                               valid;
    logic                               ready;
    rars_pkg::kind_t                    kind;
    logic [rars_pkg::IDX_W-1:0]         range_low;
    logic [rars_pkg::IDX_W-1:0]         range_high;
    logic signed [rars_pkg::VAL_W-1:0]  value;

    modport source (output valid, kind, range_low, range_high, value, input ready);
    modport sink   (input valid, kind, range_low, range_high, value, output ready);
endinterface

### hw/rtl/rars_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_rsp_if
// result channel: wrapping range sum
// ----------------------------------------------------------------------------
interface rars_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [rars_pkg::SUM_W-1:0]  range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface

### hw/rtl/range_add_range_sum_tree_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top
// lazy segment tree with range add and range sum, walked by a sequencer
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    kind, range_low, range_high, value
//  rsp      out  valid/ready    range_sum (range sum requests only)
//
//  load writes one leaf; rebuild recomputes every inner node from its
//  children, from node SPAN-1 down to the root, and clears its tag
//  add and sum walk the tree one node at a time through a single 64-bit
//  adder and shifter, up to about four nodes per level; a split node first
//  pushes its pending tag down to both children
//  after reset a clearing pass writes zero over both rams, with req.ready
//  low throughout
//  a result waits in an output register; req is taken again meanwhile
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_top (
    input  logic        clk,
    input  logic        rst_n,
    rars_req_if.sink    req,
    rars_rsp_if.source  rsp
);
    import rars_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_VISIT,
        S_COV0, S_COV1, S_COV2,
        S_PUSH0, S_PUSH1, S_PUSH2, S_PUSH3, S_PUSH4, S_PUSH5,
        S_UP, S_RET, S_R0, S_R1, S_R2, S_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [NW-1:0]      clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;

    // walk context
    logic [NW-1:0]      node_reg, node_next;
    logic [LW-1:0]      lvl_reg, lvl_next;
    logic               from_left_reg, from_left_next;
    kind_t              op_reg, op_next;
    logic [CW-1:0]      a_reg, a_next, b_reg, b_next;
    logic [SUM_W-1:0]   x_reg, x_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [SUM_W-1:0]   hold_reg, hold_next;
    logic [SUM_W-1:0]   tagv_reg, tagv_next;

    // ram ports
    logic                  sum_we, sum_re, tag_we, tag_re;
    logic [NW-1:0]         sum_waddr, sum_raddr;
    logic [TREE_LVLS-1:0]  tag_waddr, tag_raddr;
    logic [SUM_W-1:0]      sum_wdata, tag_wdata, sum_rd, tag_rd;

    // shared arithmetic
    logic [SUM_W-1:0]   add_a, add_b, add_y, shift_src, shift_y;
    logic [LW-1:0]      shift_amt;

    // node geometry
    logic [LW-1:0]          sh;
    logic [2*NW-1:0]        node_wide;
    logic [TREE_LVLS-1:0]   span_mask, nlo, nhi, nmid;
    logic [CW-1:0]          lo_c, hi_c, mid_c;
    logic                   covered, go_left, go_right, is_leaf, child_leaf;
    logic [NW-1:0]          child_l, child_r;

    // request decode
    logic [CW-1:0]      req_lo, req_hi, hi_clamp;
    logic [SUM_W-1:0]   req_x;

    rars_ram #(.WIDTH(SUM_W), .DEPTH(2 * SPAN)) u_sums (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rd)
    );

    // tags are kept for inner nodes only; a tag read at a leaf is never used
    rars_ram #(.WIDTH(SUM_W), .DEPTH(SPAN)) u_tags (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rd)
    );

    assign add_y   = add_a + add_b;
    assign shift_y = shift_src << shift_amt;

    // node p at level l covers a power-of-two block, so sizes are shifts
    assign sh         = LW'(TREE_LVLS) - lvl_reg;
    assign node_wide  = {{NW{1'b0}}, node_reg} << sh;
    assign span_mask  = {TREE_LVLS{1'b1}} >> lvl_reg;
    assign nlo        = node_wide[TREE_LVLS-1:0];
    assign nhi        = nlo | span_mask;
    assign nmid       = nlo | (span_mask >> 1);
    assign lo_c       = CW'(nlo);
    assign hi_c       = CW'(nhi);
    assign mid_c      = CW'(nmid);
    assign covered    = (a_reg <= lo_c) && (hi_c <= b_reg);
    assign go_left    = (a_reg <= mid_c);
    assign go_right   = (b_reg > mid_c);
    assign is_leaf    = (lvl_reg == LW'(TREE_LVLS));
    assign child_leaf = (lvl_reg == LW'(TREE_LVLS - 1));
    assign child_l    = {node_reg[NW-2:0], 1'b0};
    assign child_r    = {node_reg[NW-2:0], 1'b1};

    assign req_lo   = CW'(req.range_low);
    assign req_hi   = CW'(req.range_high);
    assign hi_clamp = (req_hi > LAST_IDX) ? LAST_IDX : req_hi;
    assign req_x    = {{(SUM_W - VAL_W){req.value[VAL_W-1]}}, req.value};

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.range_sum = $signed(out_sum_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        node_next      = node_reg;
        lvl_next       = lvl_reg;
        from_left_next = from_left_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        tagv_next      = tagv_reg;

        sum_we    = 1'b0;
        sum_waddr = node_reg;
        sum_wdata = add_y;
        sum_re    = 1'b0;
        sum_raddr = node_reg;
        tag_we    = 1'b0;
        tag_waddr = node_reg[TREE_LVLS-1:0];
        tag_wdata = add_y;
        tag_re    = 1'b0;
        tag_raddr = node_reg[TREE_LVLS-1:0];
        add_a     = sum_rd;
        add_b     = shift_y;
        shift_src = x_reg;
        shift_amt = sh;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
                sum_wdata = '0;
                tag_we    = 1'b1;
                tag_waddr = clr_reg[TREE_LVLS-1:0];
                tag_wdata = '0;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.kind;
                    a_next    = req_lo;
                    b_next    = hi_clamp;
                    x_next    = req_x;
                    node_next = NW'(1);
                    lvl_next  = '0;
                    acc_next  = '0;
                    case (req.kind)
                        KIND_LOAD:
                        begin
                            state_next = (req_lo <= LAST_IDX) ? S_LOAD : S_IDLE;
                        end
                        KIND_REBUILD:
                        begin
                            node_next  = NW'(SPAN - 1);
                            state_next = S_R0;
                        end
                        KIND_ADD:
                        begin
                            state_next = (req_lo <= hi_clamp) ? S_VISIT : S_IDLE;
                        end
                        default:
                        begin
                            state_next = (req_lo <= hi_clamp) ? S_VISIT : S_FIN;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                sum_we     = 1'b1;
                sum_waddr  = NW'(SPAN) + NW'(a_reg);
                sum_wdata  = x_reg;
                state_next = S_IDLE;
            end
            S_VISIT:
            begin
                state_next = covered ? S_COV0 : S_PUSH0;
            end
            S_COV0:
            begin
                sum_re     = 1'b1;
                tag_re     = 1'b1;
                state_next = S_COV1;
            end
            S_COV1:
            begin
                if (op_reg == KIND_SUM)
                begin
                    add_a      = acc_reg;
                    add_b      = sum_rd;
                    acc_next   = add_y;
                    state_next = S_RET;
                end
                else
                begin
                    sum_we     = 1'b1;
                    state_next = S_COV2;
                end
            end
            S_COV2:
            begin
                add_a      = tag_rd;
                add_b      = x_reg;
                tag_we     = !is_leaf;
                state_next = S_RET;
            end
            S_PUSH0:
            begin
                tag_re     = 1'b1;
                state_next = S_PUSH1;
            end
            S_PUSH1:
            begin
                tagv_next  = tag_rd;
                tag_we     = 1'b1;
                tag_wdata  = '0;
                tag_re     = 1'b1;
                tag_raddr  = child_l[TREE_LVLS-1:0];
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                add_a      = tag_rd;
                add_b      = tagv_reg;
                tag_we     = !child_leaf;
                tag_waddr  = child_l[TREE_LVLS-1:0];
                tag_re     = 1'b1;
                tag_raddr  = child_r[TREE_LVLS-1:0];
                state_next = S_PUSH3;
            end
            S_PUSH3:
            begin
                add_a      = tag_rd;
                add_b      = tagv_reg;
                tag_we     = !child_leaf;
                tag_waddr  = child_r[TREE_LVLS-1:0];
                sum_re     = 1'b1;
                sum_raddr  = child_l;
                state_next = S_PUSH4;
            end
            S_PUSH4:
            begin
                shift_src  = tagv_reg;
                shift_amt  = sh - LW'(1);
                sum_we     = 1'b1;
                sum_waddr  = child_l;
                sum_re     = 1'b1;
                sum_raddr  = child_r;
                state_next = S_PUSH5;
            end
            S_PUSH5:
            begin
                shift_src  = tagv_reg;
                shift_amt  = sh - LW'(1);
                sum_we     = 1'b1;
                sum_waddr  = child_r;
                node_next  = go_left ? child_l : child_r;
                lvl_next   = lvl_reg + LW'(1);
                state_next = S_VISIT;
            end
            S_UP:
            begin
                if (from_left_reg && go_right)
                begin
                    node_next  = child_r;
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_VISIT;
                end
                else if (op_reg == KIND_ADD)
                begin
                    state_next = S_R0;
                end
                else
                begin
                    state_next = S_RET;
                end
            end
            S_RET:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = (op_reg == KIND_SUM) ? S_FIN : S_IDLE;
                end
                else
                begin
                    from_left_next = !node_reg[0];
                    node_next      = node_reg >> 1;
                    lvl_next       = lvl_reg - LW'(1);
                    state_next     = S_UP;
                end
            end
            S_R0:
            begin
                sum_re     = 1'b1;
                sum_raddr  = child_l;
                state_next = S_R1;
            end
            S_R1:
            begin
                hold_next  = sum_rd;
                sum_re     = 1'b1;
                sum_raddr  = child_r;
                state_next = S_R2;
            end
            S_R2:
            begin
                add_a  = hold_reg;
                add_b  = sum_rd;
                sum_we = 1'b1;
                if (op_reg == KIND_REBUILD)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = '0;
                    if (node_reg == NW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        node_next  = node_reg - NW'(1);
                        state_next = S_R0;
                    end
                end
                else
                begin
                    state_next = S_RET;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_sum_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            out_sum_reg   <= out_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        lvl_reg       <= lvl_next;
        from_left_reg <= from_left_next;
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        hold_reg      <= hold_next;
        tagv_reg      <= tagv_next;
    end

    // nothing touches the rams while a request may be taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !sum_we && !tag_we)
        else $error("ram write while idle");

    // the walk keeps node and level consistent
    a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VISIT |-> (node_reg >> lvl_reg) == NW'(1))
        else $error("node does not match its level");

    // tags are never pushed below a leaf
    a_push_inner: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH0 |-> lvl_reg < LW'(TREE_LVLS))
        else $error("push at a leaf");

    // a result only ever comes from a range sum
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN && op_reg == KIND_SUM)
        else $error("result without a range sum request");

endmodule

### hw/rtl/rars_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rars_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### verif/range_add_range_sum_tree_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_checker
// watches both channels, keeps a lazy segment tree of its own and checks
// every range sum against it
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_checker (
    input  logic    clk,
    input  logic    rst_n,
    rars_req_if     req,
    rars_rsp_if     rsp,
    output int      fail_count,
    output int      sums_waiting,
    output int      sums_checked
);
    import rars_pkg::*;

    typedef struct {
        int p;
        int lo;
        int hi;
        bit post;
    } walk_t;

    logic [SUM_W-1:0] tree_sum [0:2*SPAN-1];
    logic [SUM_W-1:0] tree_tag [0:2*SPAN-1];
    logic [SUM_W-1:0] sums_due [$];

    function automatic void push_tag(int p, int lo, int hi);
        logic [SUM_W-1:0] tag;
        int mid;
        tag = tree_tag[p];
        if (tag == 0 || lo >= hi)
            return;
        mid = lo + (hi - lo) / 2;
        tree_tag[2*p]   += tag;
        tree_tag[2*p+1] += tag;
        tree_sum[2*p]   += tag * SUM_W'(mid - lo + 1);
        tree_sum[2*p+1] += tag * SUM_W'(hi - mid);
        tree_tag[p] = '0;
    endfunction

    // one walk serves both add and sum; the stack keeps the recursive order
    function automatic logic [SUM_W-1:0] walk_range(bit is_add, int a, int b,
                                                    logic [SUM_W-1:0] x);
        walk_t stack [$];
        walk_t f;
        int mid;
        logic [SUM_W-1:0] acc;
        acc = '0;
        stack.push_back('{1, 0, SPAN-1, 1'b0});
        while (stack.size() > 0) begin
            f = stack.pop_back();
            if (f.post) begin
                tree_sum[f.p] = tree_sum[2*f.p] + tree_sum[2*f.p+1];
                continue;
            end
            if (a <= f.lo && f.hi <= b) begin
                if (is_add) begin
                    tree_sum[f.p] += x * SUM_W'(f.hi - f.lo + 1);
                    tree_tag[f.p] += x;
                end
                else
                    acc += tree_sum[f.p];
                continue;
            end
            push_tag(f.p, f.lo, f.hi);
            mid = f.lo + (f.hi - f.lo) / 2;
            if (is_add)
                stack.push_back('{f.p, f.lo, f.hi, 1'b1});
            if (b > mid)
                stack.push_back('{2*f.p+1, mid+1, f.hi, 1'b0});
            if (a <= mid)
                stack.push_back('{2*f.p, f.lo, mid, 1'b0});
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [SUM_W-1:0] x;
        logic [SUM_W-1:0] want;
        int lo;
        int hi;
        if (!rst_n) begin
            for (int i = 0; i < 2*SPAN; i++)
            begin
                tree_sum[i] = '0;
                tree_tag[i] = '0;
            end
            sums_due.delete();
            fail_count   <= 0;
            sums_checked <= 0;
            sums_waiting <= 0;
        end
        else begin
            // result first, it belongs to an earlier request
            if (rsp.valid && rsp.ready) begin
                if (sums_due.size() == 0) begin
                    $display("%0t: unexpected range_sum %0d", $time, rsp.range_sum);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = sums_due.pop_front();
                    if (rsp.range_sum !== want) begin
                        $display("%0t: range_sum expected %0d actual %0d", $time,
                                 $signed(want), rsp.range_sum);
                        fail_count <= fail_count + 1;
                    end
                end
                sums_checked <= sums_checked + 1;
            end
            if (req.valid && req.ready) begin
                x  = SUM_W'(req.value);
                lo = int'(req.range_low);
                hi = int'(req.range_high);
                if (hi > LEAVES - 1)
                    hi = LEAVES - 1;
                case (req.kind)
                    KIND_LOAD:
                        if (lo < LEAVES)
                            tree_sum[SPAN+lo] = x;
                    KIND_REBUILD:
                    begin
                        for (int i = SPAN - 1; i >= 1; i--)
                            tree_sum[i] = tree_sum[2*i] + tree_sum[2*i+1];
                        for (int i = 0; i < 2*SPAN; i++)
                            tree_tag[i] = '0;
                    end
                    KIND_ADD:
                        if (lo <= hi)
                            void'(walk_range(1'b1, lo, hi, x));
                    default:
                        sums_due.push_back(lo <= hi ? walk_range(1'b0, lo, hi, '0) : '0);
                endcase
            end
            sums_waiting <= sums_due.size();
        end
    end

endmodule

### verif/range_add_range_sum_tree_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top_test
// drives loads, rebuilds, range adds and range sums into the segment tree
// with random gaps and back-pressure; the checker judges every sum
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_top_test;
    import rars_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   sums_waiting;
    int   sums_checked;

    // sender/receiver behaviour switches
    bit   calm_phase;
    bit   hold_wanted;
    bit   hold_done;

    int   requests_sent;
    int   adds_sent;
    int   loads_sent;
    int   rebuilds_sent;

    rars_req_if req ();
    rars_rsp_if rsp ();

    range_add_range_sum_tree_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    range_add_range_sum_tree_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .sums_waiting (sums_waiting),
        .sums_checked (sums_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous ceiling: clearing pass, rebuilds and long receiver stalls
    initial
    begin
        #30ms;
        $display("timeout with %0d sums outstanding", sums_waiting);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, one long hold-off counted here, calm stretch
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_done)
            begin
                rsp.ready <= 1'b0;
                repeat (800) @(posedge clk);
                hold_done = 1'b1;
                rsp.ready <= 1'b1;
            end
            else if (calm_phase)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(99) >= 24);
        end
    end

    // offer one request and hold it until taken; called at a rising edge
    task automatic send_request(kind_t k, logic [IDX_W-1:0] lo,
                                logic [IDX_W-1:0] hi, logic [VAL_W-1:0] v);
        if (!calm_phase && $urandom_range(99) < 24)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.kind       <= k;
        req.range_low  <= lo;
        req.range_high <= hi;
        req.value      <= v;
        // ready only moves at rising edges, so the falling edge shows it safely
        do
            @(negedge clk);
        while (!req.ready);
        @(posedge clk);
        requests_sent++;
        case (k)
            KIND_LOAD:    loads_sent++;
            KIND_REBUILD: rebuilds_sent++;
            KIND_ADD:     adds_sent++;
            default:      ;
        endcase
    endtask

    // sender pause until every expected sum is back
    task automatic drain_sums();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sums_waiting != 0)
            @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int r;
        int lo;
        int hi;
        kind_t k;
        calm_phase    = 1'b0;
        hold_wanted   = 1'b0;
        hold_done     = 1'b0;
        requests_sent = 0;
        adds_sent     = 0;
        loads_sent    = 0;
        rebuilds_sent = 0;
        req.valid      <= 1'b0;
        req.kind       <= KIND_LOAD;
        req.range_low  <= '0;
        req.range_high <= '0;
        req.value      <= '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: untouched tree, extreme leaves, rebuild, full-width adds
        send_request(KIND_SUM, 10'd0, 10'd1023, '0);
        send_request(KIND_LOAD, 10'd0, 10'd0, 32'h7fff_ffff);
        send_request(KIND_LOAD, 10'd1023, 10'd0, 32'h8000_0000);
        send_request(KIND_LOAD, 10'd511, 10'd0, 32'hffff_ffff);
        send_request(KIND_REBUILD, 10'd0, 10'd0, '0);
        send_request(KIND_SUM, 10'd0, 10'd1023, '0);
        send_request(KIND_SUM, 10'd1023, 10'd1023, '0);
        send_request(KIND_ADD, 10'd0, 10'd1023, 32'h7fff_ffff);
        send_request(KIND_ADD, 10'd1, 10'd1022, 32'h8000_0000);
        send_request(KIND_SUM, 10'd0, 10'd1023, '0);
        send_request(KIND_SUM, 10'd0, 10'd0, '0);
        // empty range: add changes nothing and sum gives zero
        send_request(KIND_ADD, 10'd700, 10'd300, 32'h1234_5678);
        send_request(KIND_SUM, 10'd1023, 10'd0, '0);
        // load beneath a pending tag, then read it before and after a rebuild
        send_request(KIND_ADD, 10'd256, 10'd767, 32'd5);
        send_request(KIND_LOAD, 10'd300, 10'd0, 32'd9);
        send_request(KIND_SUM, 10'd290, 10'd310, '0);
        send_request(KIND_SUM, 10'd0, 10'd1023, '0);
        send_request(KIND_REBUILD, 10'd0, 10'd0, '0);
        send_request(KIND_SUM, 10'd290, 10'd310, '0);
        send_request(KIND_SUM, 10'd512, 10'd512, '0);
        send_request(KIND_ADD, 10'd3, 10'd3, 32'hffff_ffff);
        send_request(KIND_SUM, 10'd2, 10'd4, '0);
        drain_sums();

        // random: mostly adds and sums over short spans, some with a random upper bound
        for (int n = 0; n < 1750; n++)
        begin
            if (n == 400)
                hold_wanted = 1'b1;
            calm_phase = (n >= 800 && n < 1000);
            if (n == 1200)
                drain_sums();
            r = $urandom_range(99);
            if (r < 12)
                k = KIND_LOAD;
            else if (r < 13)
                k = KIND_REBUILD;
            else if (r < 55)
                k = KIND_ADD;
            else
                k = KIND_SUM;
            lo = $urandom_range(1023);
            if ($urandom_range(7) == 0)
                hi = $urandom_range(1023);
            else
            begin
                hi = lo + $urandom_range(63);
                if (hi > 1023)
                    hi = 1023;
            end
            send_request(k, IDX_W'(lo), IDX_W'(hi), pick_value());
        end
        req.valid <= 1'b0;

        while (sums_waiting != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("run covered %0d requests: %0d loads, %0d rebuilds, %0d adds",
                 requests_sent, loads_sent, rebuilds_sent, adds_sent);
        $display("%0d range sums compared, with stalls and a long output hold-off",
                 sums_checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
